// ===== rtl/csblit_pkg.sv =====
// Shared types and constants for the clipped transparent sprite blitter.
`default_nettype none
package csblit_pkg;

    localparam int DEFAULT_PITCH = 320;
    localparam int MAX_DIM       = 1024;
    localparam int MIN_WIDTH     = 4;

    localparam int POS_W   = 12;
    localparam int COORD_W = 13;
    localparam int DIM_W   = 10;
    localparam int ADDR_W  = 20;
    localparam int PIX_W   = 8;
    localparam int PROD_W  = DIM_W + 1 + POS_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    localparam logic [DIM_W-1:0] CLIP_RIGHT_RST  = 10'd320;
    localparam logic [DIM_W-1:0] CLIP_BOTTOM_RST = 10'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_TOP    = 3'd1,
        CFG_CLIP_RIGHT  = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_FRAME_BASE  = 3'd4
    } cfg_index_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One classified item as it waits between front and back.
    typedef struct packed {
        logic               is_header;
        logic               active;
        logic [PIX_W-1:0]   pixel;
        coord_t             ox;
        coord_t             oy;
        coord_t             wx0;
        coord_t             wx1;
        coord_t             wy0;
        coord_t             wy1;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DIM_W-1:0]   pitch;
        logic [ADDR_W-1:0]  row_base;
    } qentry_t;

endpackage
`default_nettype wire

// ===== rtl/csblit_front.sv =====
// Front end: register file, item accept and two-stage header classification.
`default_nettype none
module csblit_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [csblit_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  cfg_we,
    input  logic [csblit_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csblit_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  q_pop,
    output logic                                  push_valid,
    output csblit_pkg::qentry_t                   push_entry
);
    import csblit_pkg::*;

    logic [DIM_W-1:0]  clip_left_reg;
    logic [DIM_W-1:0]  clip_top_reg;
    logic [DIM_W-1:0]  clip_right_reg;
    logic [DIM_W-1:0]  clip_bottom_reg;
    logic [ADDR_W-1:0] frame_base_reg;

    logic [QCNT_W-1:0] occ_reg;
    logic              v1_reg;
    logic              v2_reg;
    qentry_t           s1_reg;
    qentry_t           s2_reg;
    logic signed [PROD_W-1:0] prod1_reg;

    logic                     accept;
    logic [POS_W-1:0]         in_pos_x;
    logic [POS_W-1:0]         in_pos_y;
    logic [DIM_W-1:0]         in_w;
    logic [DIM_W-1:0]         in_h;
    logic [DIM_W-1:0]         in_p;
    logic [PIX_W-1:0]         in_pix;
    logic [DIM_W-1:0]         w_c;
    logic [DIM_W-1:0]         h_c;
    logic [DIM_W-1:0]         pitch_c;
    coord_t                   ox_c;
    coord_t                   oy_c;
    coord_t                   x_end;
    coord_t                   y_end;
    coord_t                   cl;
    coord_t                   ct;
    coord_t                   cr;
    coord_t                   cb;
    logic signed [PROD_W-1:0] prod_c;
    qentry_t                  s1_next;
    qentry_t                  s2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= CLIP_RIGHT_RST;
            clip_bottom_reg <= CLIP_BOTTOM_RST;
            frame_base_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data[DIM_W-1:0];
                CFG_CLIP_TOP:    clip_top_reg    <= cfg_data[DIM_W-1:0];
                CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[DIM_W-1:0];
                CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[DIM_W-1:0];
                CFG_FRAME_BASE:  frame_base_reg  <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Credit covers both stages and the queue, so the stages never stall.
    assign s_tready = (occ_reg < QCNT_W'(QDEPTH));
    assign accept   = s_tvalid && s_tready;

    assign in_pos_x = s_tdata[11:0];
    assign in_pos_y = s_tdata[23:12];
    assign in_w     = s_tdata[33:24];
    assign in_h     = s_tdata[43:34];
    assign in_p     = s_tdata[53:44];
    assign in_pix   = s_tdata[61:54];

    always_comb
    begin
        w_c     = (32'(in_w) > MAX_DIM - 1) ? DIM_W'(MAX_DIM - 1) : in_w;
        h_c     = (32'(in_h) > MAX_DIM - 1) ? DIM_W'(MAX_DIM - 1) : in_h;
        pitch_c = (in_p == '0) ? DIM_W'(DEFAULT_PITCH) : in_p;
        ox_c    = $signed({in_pos_x[POS_W-1], in_pos_x});
        oy_c    = $signed({in_pos_y[POS_W-1], in_pos_y});
        x_end   = ox_c + $signed({3'b000, w_c});
        y_end   = oy_c + $signed({3'b000, h_c});
        cl      = $signed({3'b000, clip_left_reg});
        ct      = $signed({3'b000, clip_top_reg});
        cr      = $signed({3'b000, clip_right_reg});
        cb      = $signed({3'b000, clip_bottom_reg});
        prod_c  = $signed({1'b0, pitch_c}) * $signed(in_pos_y);

        s1_next           = '0;
        s1_next.is_header = (s_tuser == CMD_HEADER);
        s1_next.pixel     = in_pix;
        s1_next.ox        = ox_c;
        s1_next.oy        = oy_c;
        s1_next.w         = w_c;
        s1_next.h         = h_c;
        s1_next.pitch     = pitch_c;
        s1_next.wx0       = (ox_c > cl) ? ox_c : cl;
        s1_next.wx1       = (x_end < cr) ? x_end : cr;
        s1_next.wy0       = (oy_c > ct) ? oy_c : ct;
        s1_next.wy1       = (y_end < cb) ? y_end : cb;

        s2_next          = s1_reg;
        s2_next.row_base = frame_base_reg + prod1_reg[ADDR_W-1:0];
        // Drop when too small or fewer than 2 columns or no rows are visible.
        s2_next.active   = (s1_reg.h != '0)
                        && (32'(s1_reg.w) >= MIN_WIDTH)
                        && (s1_reg.wx1 > s1_reg.wx0 + COORD_W'(1))
                        && (s1_reg.wy1 > s1_reg.wy0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_reg + QCNT_W'(accept) - QCNT_W'(q_pop);
            v1_reg  <= accept;
            v2_reg  <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        prod1_reg <= prod_c;
        s2_reg    <= s2_next;
    end

    assign push_valid = v2_reg;
    assign push_entry = s2_reg;

endmodule
`default_nettype wire

// ===== rtl/csblit_fifo.sv =====
// Short queue of classified items between front and back.
`default_nettype none
module csblit_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csblit_pkg::qentry_t push_entry,
    input  logic                pop,
    output logic                head_valid,
    output csblit_pkg::qentry_t head_entry
);
    import csblit_pkg::*;

    qentry_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ===== rtl/csblit_back.sv =====
// Back end: raster walk over the sprite, clip test and output register.
`default_nettype none
module csblit_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  csblit_pkg::qentry_t                  q_entry,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csblit_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import csblit_pkg::*;

    logic              active_reg;
    logic [DIM_W-1:0]  col_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  pitch_reg;
    logic [ADDR_W-1:0] row_base_reg;
    coord_t            ox_reg;
    coord_t            sx_reg;
    coord_t            sy_reg;
    coord_t            wx0_reg;
    coord_t            wx1_reg;
    coord_t            wy0_reg;
    coord_t            wy1_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [PIX_W-1:0]  out_color_reg;

    logic              pix_go;
    logic              hit;
    logic              col_last;
    logic              row_last;
    logic [ADDR_W-1:0] addr;

    assign q_pop  = q_valid && (!out_valid_reg || m_tready);
    assign pix_go = q_pop && !q_entry.is_header && active_reg;

    assign hit = (q_entry.pixel != '0)
              && (sx_reg >= wx0_reg) && (sx_reg < wx1_reg)
              && (sy_reg >= wy0_reg) && (sy_reg < wy1_reg);

    assign addr     = row_base_reg
                    + {{(ADDR_W-COORD_W){sx_reg[COORD_W-1]}}, sx_reg};
    assign col_last = ({1'b0, col_reg} + (DIM_W+1)'(1)) == {1'b0, width_reg};
    assign row_last = ({1'b0, row_reg} + (DIM_W+1)'(1)) == {1'b0, height_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            pitch_reg    <= DIM_W'(DEFAULT_PITCH);
            row_base_reg <= '0;
            ox_reg       <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            wx0_reg      <= '0;
            wx1_reg      <= '0;
            wy0_reg      <= '0;
            wy1_reg      <= '0;
        end
        else if (q_pop && q_entry.is_header)
        begin
            // A new header abandons whatever sprite was in progress.
            active_reg   <= q_entry.active;
            col_reg      <= '0;
            row_reg      <= '0;
            width_reg    <= q_entry.w;
            height_reg   <= q_entry.h;
            pitch_reg    <= q_entry.pitch;
            row_base_reg <= q_entry.row_base;
            ox_reg       <= q_entry.ox;
            sx_reg       <= q_entry.ox;
            sy_reg       <= q_entry.oy;
            wx0_reg      <= q_entry.wx0;
            wx1_reg      <= q_entry.wx1;
            wy0_reg      <= q_entry.wy0;
            wy1_reg      <= q_entry.wy1;
        end
        else if (pix_go)
        begin
            if (col_last)
            begin
                col_reg      <= '0;
                row_reg      <= row_reg + DIM_W'(1);
                sx_reg       <= ox_reg;
                sy_reg       <= sy_reg + COORD_W'(1);
                row_base_reg <= row_base_reg + {{(ADDR_W-DIM_W){1'b0}}, pitch_reg};
                if (row_last)
                    active_reg <= 1'b0;
            end
            else
            begin
                col_reg <= col_reg + DIM_W'(1);
                sx_reg  <= sx_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pix_go && hit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pix_go && hit)
        begin
            out_addr_reg  <= addr;
            out_color_reg <= q_entry.pixel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-ADDR_W-PIX_W){1'b0}}, out_color_reg, out_addr_reg};

endmodule
`default_nettype wire

// ===== rtl/clipped_transparent_sprite_blit.sv =====
// Path: an opaque, visible pixel item passes the two classify stages, the queue and the output register to m_tvalid.
// Throughput: one item per cycle, headers and pixels alike, while m_tready stays high;
// at most 4 items sit between s_tready and the output register (two classify stages
// plus the queue), which sets how long input keeps flowing under output backpressure.
// Reset: rst_n clears asynchronously; clip rectangle returns to 0,0,320,200, frame
// base to 0, no sprite active, queue and output empty. No clearing pass is needed.
`default_nettype none
module clipped_transparent_sprite_blit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pos_x[11:0], pos_y[23:12], sprite_width[33:24], sprite_height[43:34],
    // dest_pitch[53:44], pixel_value[61:54], zero fill above
    input  logic [csblit_pkg::IN_TDATA_W-1:0]    s_tdata,
    // command (0 header, 1 pixel)
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // write_address[19:0], write_color[27:20], zero fill above
    output logic [csblit_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                 cfg_we,
    input  logic [csblit_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csblit_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import csblit_pkg::*;

    logic    push_valid;
    qentry_t push_entry;
    logic    head_valid;
    qentry_t head_entry;
    logic    q_pop;

    csblit_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_pop      (q_pop),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    csblit_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    csblit_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (head_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/csblit_checker.sv =====
// Port-level checks for the sprite blitter and their bind to the top level.
`default_nettype none
module csblit_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [csblit_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import csblit_pkg::*;

    // Hold a stalled result steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Transparent pixels never make a write.
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ADDR_W +: PIX_W] != '0))
        else $error("write with transparent color");

    // With the output drained the back end empties the queue, so input is open.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!m_tvalid) |-> s_tready)
        else $error("input stalled while output was free");

    // An edge seen in reset leaves the output empty.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind clipped_transparent_sprite_blit csblit_checker u_csblit_checker (.*);
`default_nettype wire
